// ----- rtl/canonical_sexp_length_scanner_defines.svh -----
// Assertion helpers shared by the scanner modules.
`ifndef CANONICAL_SEXP_LENGTH_SCANNER_DEFINES_SVH
`define CANONICAL_SEXP_LENGTH_SCANNER_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define CSLS_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CSLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/csls_pkg.sv -----
`default_nettype none

package csls_pkg;

    localparam int DEF_MAX_BUFFER_BYTES = 65535;
    localparam int DEF_MAX_NEST_DEPTH   = 255;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_SYNTAX     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] expr_length;
    } t_out;

    // Byte after classification by the front end
    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic       is_colon;
        logic       is_digit;
        logic [3:0] digit;
        logic       last;
    } t_cls;

    typedef enum logic [5:0] {
        M_OPEN    = 6'b000001,
        M_ELEMENT = 6'b000010,
        M_DIGITS  = 6'b000100,
        M_DATA    = 6'b001000,
        M_NOCOLON = 6'b010000,
        M_SKIP    = 6'b100000
    } t_mode;

endpackage

`default_nettype wire

// ----- rtl/csls_front.sv -----
`default_nettype none

module csls_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire csls_pkg::t_in i_item,
    output logic               o_cls_valid,
    output csls_pkg::t_cls     o_cls,
    input  wire logic          i_pop
);

    csls_pkg::t_cls r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           accept;
    logic           take;
    csls_pkg::t_cls cls;

    always_comb begin
        cls.is_open  = (i_item.data_byte == csls_pkg::CH_OPEN);
        cls.is_close = (i_item.data_byte == csls_pkg::CH_CLOSE);
        cls.is_colon = (i_item.data_byte == csls_pkg::CH_COLON);
        cls.is_digit = (i_item.data_byte >= csls_pkg::CH_ZERO) &&
                       (i_item.data_byte <= csls_pkg::CH_NINE);
        cls.digit    = i_item.data_byte[3:0];
        cls.last     = i_item.last_byte;
    end

    assign full        = (r_cnt == 2'd2);
    assign accept      = push && !full;
    assign o_cls_valid = (r_cnt != 2'd0);
    assign take        = i_pop && o_cls_valid;
    assign o_cls       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (take) begin
                r_rp <= ~r_rp;
            end
            case ({accept, take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`include "canonical_sexp_length_scanner_defines.svh"

    `CSLS_ASSERT_ALWAYS(a_front_cnt, i_clk, i_rst_n, r_cnt <= 2'd2, "front queue overfilled")
    `CSLS_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, full && !i_pop, full, "front request lost")

endmodule

`default_nettype wire

// ----- rtl/csls_back.sv -----
`default_nettype none

module csls_back #(
    parameter int MAX_BUFFER_BYTES = csls_pkg::DEF_MAX_BUFFER_BYTES,
    parameter int MAX_NEST_DEPTH   = csls_pkg::DEF_MAX_NEST_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cls_valid,
    input  wire csls_pkg::t_cls i_cls,
    output logic                o_cls_pop,
    output logic                empty,
    input  wire logic           pop,
    output csls_pkg::t_out      o_result
);

    localparam int POS_W   = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int DEPTH_W = $clog2(MAX_NEST_DEPTH + 1);
    localparam logic [POS_W-1:0]   MAX_POS   = POS_W'(MAX_BUFFER_BYTES);
    localparam logic [POS_W+3:0]   MAX_V     = (POS_W + 4)'(MAX_BUFFER_BYTES);
    localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_NEST_DEPTH);

    csls_pkg::t_mode    r_mode, n_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_accum, n_accum;
    logic [POS_W:0]     r_pending, n_pending;

    csls_pkg::t_out     r_oq [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;

    logic               take;
    logic               out_take;
    logic               have;
    csls_pkg::t_out     res;
    logic [POS_W-1:0]   pos;
    logic [POS_W+3:0]   v;
    logic [31:0]        pos32;
    logic               restart;

    assign take      = i_cls_valid && (r_ocnt != 2'd2);
    assign o_cls_pop = take;
    assign empty     = (r_ocnt == 2'd0);
    assign out_take  = pop && !empty;
    assign o_result  = r_oq[r_orp];

    always_comb begin
        pos       = r_pos + POS_W'(1);
        pos32     = 32'(pos);
        v         = (POS_W + 4)'({r_accum, 3'b000}) + (POS_W + 4)'({r_accum, 1'b0})
                    + (POS_W + 4)'(i_cls.digit);
        have      = 1'b0;
        res.status      = csls_pkg::ST_COMPLETE;
        res.expr_length = 16'd0;
        n_mode    = r_mode;
        n_depth   = r_depth;
        n_pos     = pos;
        n_accum   = r_accum;
        n_pending = r_pending;
        restart   = 1'b0;

        unique case (r_mode)
            csls_pkg::M_OPEN: begin
                if (i_cls.is_open) begin
                    n_mode  = csls_pkg::M_ELEMENT;
                    n_depth = '0;
                end else begin
                    have       = 1'b1;
                    res.status = csls_pkg::ST_SYNTAX;
                end
            end
            csls_pkg::M_ELEMENT: begin
                if (i_cls.is_open) begin
                    if (r_depth >= MAX_DEPTH) begin
                        have       = 1'b1;
                        res.status = csls_pkg::ST_SYNTAX;
                    end else begin
                        n_depth = r_depth + DEPTH_W'(1);
                    end
                end else if (i_cls.is_close) begin
                    if (r_depth == '0) begin
                        have            = 1'b1;
                        res.status      = csls_pkg::ST_COMPLETE;
                        res.expr_length = (pos32 > 32'd65535) ? 16'hFFFF : pos32[15:0];
                    end else begin
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                end else if (i_cls.is_digit) begin
                    n_accum = POS_W'(i_cls.digit);
                    n_mode  = csls_pkg::M_DIGITS;
                end else begin
                    have       = 1'b1;
                    res.status = csls_pkg::ST_SYNTAX;
                end
            end
            csls_pkg::M_DIGITS: begin
                if (i_cls.is_digit) begin
                    // length saturates at the buffer limit, which can never be met
                    if ((r_accum >= MAX_POS) || (v > MAX_V)) begin
                        n_accum = MAX_POS;
                    end else begin
                        n_accum = v[POS_W-1:0];
                    end
                end else if (r_accum == '0) begin
                    have       = 1'b1;
                    res.status = csls_pkg::ST_SYNTAX;
                end else begin
                    n_pending = {1'b0, pos} + {1'b0, r_accum};
                    n_mode    = i_cls.is_colon ? csls_pkg::M_DATA : csls_pkg::M_NOCOLON;
                end
            end
            csls_pkg::M_DATA: begin
                if ({1'b0, pos} >= r_pending) begin
                    n_mode = csls_pkg::M_ELEMENT;
                end
            end
            csls_pkg::M_NOCOLON: begin
                if ({1'b0, pos} >= r_pending) begin
                    have       = 1'b1;
                    res.status = csls_pkg::ST_SYNTAX;
                end
            end
            csls_pkg::M_SKIP: begin
                n_pos = r_pos;
            end
            default: begin
                n_mode = csls_pkg::M_OPEN;
            end
        endcase

        if (r_mode != csls_pkg::M_SKIP) begin
            if (!have && (i_cls.last || (pos == MAX_POS))) begin
                have       = 1'b1;
                res.status = csls_pkg::ST_INCOMPLETE;
            end
            if (have && !i_cls.last) begin
                n_mode = csls_pkg::M_SKIP;
            end
        end
        restart = i_cls.last;
    end

    always_ff @(posedge i_clk) begin
        if (take && have) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= csls_pkg::M_OPEN;
            r_depth   <= '0;
            r_pos     <= '0;
            r_accum   <= '0;
            r_pending <= '0;
            r_owp     <= 1'b0;
            r_orp     <= 1'b0;
            r_ocnt    <= 2'd0;
        end else begin
            if (take) begin
                if (restart) begin
                    r_mode    <= csls_pkg::M_OPEN;
                    r_depth   <= '0;
                    r_pos     <= '0;
                    r_accum   <= '0;
                    r_pending <= '0;
                end else begin
                    r_mode    <= n_mode;
                    r_depth   <= n_depth;
                    r_pos     <= n_pos;
                    r_accum   <= n_accum;
                    r_pending <= n_pending;
                end
            end
            if (take && have) begin
                r_owp <= ~r_owp;
            end
            if (out_take) begin
                r_orp <= ~r_orp;
            end
            case ({take && have, out_take})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

`include "canonical_sexp_length_scanner_defines.svh"

    `CSLS_ASSERT_ALWAYS(a_back_ocnt, i_clk, i_rst_n, r_ocnt <= 2'd2, "result queue overfilled")
    `CSLS_ASSERT_ALWAYS(a_back_depth, i_clk, i_rst_n, r_depth <= MAX_DEPTH, "nesting past limit")
    `CSLS_ASSERT_ALWAYS(a_back_pos, i_clk, i_rst_n, r_mode == csls_pkg::M_OPEN || |r_pos, "no count")

endmodule

`default_nettype wire

// ----- rtl/canonical_sexp_length_scanner.sv -----
// Channel   Handshake            Payload
// input     push / full          i_item  (data_byte, last_byte)
// result    empty / pop          o_result (status, expr_length)
//
// One byte per cycle sustained while results are popped; a request waits in the
// front queue until the scanner takes it, and its status, if any, is poppable in
// the cycle after that. Throughput is set by the combinational scan step in the
// back end; two-entry queues on each side let input and result stall independently.
// Reset is synchronous, active low, and returns the scanner to the start of a buffer.
// full rises only when both front queue entries are held by a stalled back end.
`default_nettype none

module canonical_sexp_length_scanner #(
    parameter int MAX_BUFFER_BYTES = csls_pkg::DEF_MAX_BUFFER_BYTES,
    parameter int MAX_NEST_DEPTH   = csls_pkg::DEF_MAX_NEST_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire csls_pkg::t_in i_item,
    output logic               empty,
    input  wire logic          pop,
    output csls_pkg::t_out     o_result
);

    logic           cls_valid;
    logic           cls_pop;
    csls_pkg::t_cls cls;

    csls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cls_valid (cls_valid),
        .o_cls       (cls),
        .i_pop       (cls_pop)
    );

    csls_back #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
        .MAX_NEST_DEPTH   (MAX_NEST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (cls_valid),
        .i_cls       (cls),
        .o_cls_pop   (cls_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/scan_status_checker.sv -----
`timescale 1ns / 1ps

module scan_status_checker #(
    parameter int MAX_BUFFER_BYTES = csls_pkg::DEF_MAX_BUFFER_BYTES,
    parameter int MAX_NEST_DEPTH   = csls_pkg::DEF_MAX_NEST_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic            i_full,
    input  csls_pkg::t_in   i_item,
    input  logic            i_empty,
    input  logic            i_pop,
    input  csls_pkg::t_out  i_result,
    output int              o_fail_count,
    output int              o_pending
);

    // Scanner state; M_SKIP stands for "status given, waiting for last byte"
    csls_pkg::t_mode scan_mode_q;
    int unsigned     nest_level;
    int unsigned     bytes_taken;
    int unsigned     length_value;
    int unsigned     data_end;

    csls_pkg::t_out status_due_q[$];
    int             fail_total = 0;
    int             due_total  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    function automatic void restart_buffer();
        scan_mode_q  = csls_pkg::M_OPEN;
        nest_level   = 0;
        bytes_taken  = 0;
        length_value = 0;
        data_end     = 0;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= csls_pkg::CH_ZERO) && (b <= csls_pkg::CH_NINE);
    endfunction

    // Advances the scanner by one byte; returns 1 when the byte settles the status
    function automatic bit scan_byte(input csls_pkg::t_in it, output csls_pkg::t_out res);
        bit          found;
        logic [1:0]  st;
        int unsigned span;
        int unsigned v;
        logic [7:0]  b;
        found = 1'b0;
        st    = csls_pkg::ST_COMPLETE;
        span  = 0;
        b     = it.data_byte;
        res   = '0;
        if (scan_mode_q == csls_pkg::M_SKIP) begin
            if (it.last_byte)
                restart_buffer();
            return 1'b0;
        end
        bytes_taken = bytes_taken + 1;
        case (scan_mode_q)
            csls_pkg::M_OPEN: begin
                if (b == csls_pkg::CH_OPEN) begin
                    scan_mode_q = csls_pkg::M_ELEMENT;
                    nest_level  = 0;
                end else begin
                    found = 1'b1;
                    st    = csls_pkg::ST_SYNTAX;
                end
            end
            csls_pkg::M_ELEMENT: begin
                if (b == csls_pkg::CH_OPEN) begin
                    if (nest_level >= MAX_NEST_DEPTH) begin
                        found = 1'b1;
                        st    = csls_pkg::ST_SYNTAX;
                    end else begin
                        nest_level = nest_level + 1;
                    end
                end else if (b == csls_pkg::CH_CLOSE) begin
                    if (nest_level == 0) begin
                        found = 1'b1;
                        st    = csls_pkg::ST_COMPLETE;
                        span  = bytes_taken;
                    end else begin
                        nest_level = nest_level - 1;
                    end
                end else if (is_digit(b)) begin
                    length_value = b - csls_pkg::CH_ZERO;
                    scan_mode_q  = csls_pkg::M_DIGITS;
                end else begin
                    found = 1'b1;
                    st    = csls_pkg::ST_SYNTAX;
                end
            end
            csls_pkg::M_DIGITS: begin
                if (is_digit(b)) begin
                    v = length_value * 10 + (b - csls_pkg::CH_ZERO);
                    if (length_value >= MAX_BUFFER_BYTES || v > MAX_BUFFER_BYTES)
                        v = MAX_BUFFER_BYTES;
                    length_value = v;
                end else if (length_value == 0) begin
                    found = 1'b1;
                    st    = csls_pkg::ST_SYNTAX;
                end else begin
                    data_end    = bytes_taken + length_value;
                    scan_mode_q = (b == csls_pkg::CH_COLON) ? csls_pkg::M_DATA
                                                             : csls_pkg::M_NOCOLON;
                end
            end
            csls_pkg::M_DATA: begin
                if (bytes_taken >= data_end)
                    scan_mode_q = csls_pkg::M_ELEMENT;
            end
            default: begin
                // length read but no colon: fails only once the data would have fitted
                if (bytes_taken >= data_end) begin
                    found = 1'b1;
                    st    = csls_pkg::ST_SYNTAX;
                end
            end
        endcase
        if (!found && (it.last_byte || bytes_taken >= MAX_BUFFER_BYTES)) begin
            found = 1'b1;
            st    = csls_pkg::ST_INCOMPLETE;
        end
        if (!found)
            return 1'b0;
        if (span > 65535)
            span = 65535;
        res.status      = st;
        res.expr_length = span[15:0];
        if (it.last_byte)
            restart_buffer();
        else
            scan_mode_q = csls_pkg::M_SKIP;
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input csls_pkg::t_out want,
                                            input csls_pkg::t_out got,
                                            input bit unexpected);
        if (fail_total < 10) begin
            if (unexpected)
                $display("%0t: status with none due: status=%0d length=%0d",
                         $realtime, got.status, got.expr_length);
            else
                $display("%0t: status mismatch: expected %0d/%0d, got %0d/%0d",
                         $realtime, want.status, want.expr_length,
                         got.status, got.expr_length);
        end
        fail_total = fail_total + 1;
    endfunction

    always @(posedge i_clk) begin : monitor
        csls_pkg::t_out want;
        csls_pkg::t_out got;
        if (!i_rst_n) begin
            restart_buffer();
            status_due_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (status_due_q.size() == 0) begin
                    report_mismatch('0, i_result, 1'b1);
                end else begin
                    want = status_due_q.pop_front();
                    if (i_result.status !== want.status ||
                        i_result.expr_length !== want.expr_length)
                        report_mismatch(want, i_result, 1'b0);
                end
            end
            if (i_push && !i_full) begin
                if (scan_byte(i_item, got))
                    status_due_q.push_back(got);
            end
        end
        due_total = status_due_q.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_BYTES = 630;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push    = 1'b0;
    logic           pop     = 1'b0;
    csls_pkg::t_in  i_item  = '0;
    logic           full;
    logic           empty;
    csls_pkg::t_out o_result;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;
    int          bytes_sent  = 0;
    logic [7:0]  buffer_bytes[$];

    always #1 i_clk = ~i_clk;

    canonical_sexp_length_scanner uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    scan_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge that took the request
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        bit took;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= {b, last};
        do begin
            @(negedge i_clk);
            took = !full;
            @(posedge i_clk);
        end while (!took);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        int n;
        n = buffer_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(buffer_bytes[i], i == n - 1);
        buffer_bytes.delete();
    endtask

    function automatic void append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            buffer_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_text(input string s);
        append_text(s);
        send_buffer();
    endtask

    function automatic void append_atom();
        int         n;
        logic [7:0] sep;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        case ($urandom_range(0, 19))
            0:       append_text("0");
            1:       append_text("00");
            2:       append_text($sformatf("0%0d", n));
            default: append_text($sformatf("%0d", n));
        endcase
        sep = csls_pkg::CH_COLON;
        if ($urandom_range(0, 19) == 0) begin
            sep = random_byte();
            if (sep == csls_pkg::CH_COLON ||
                (sep >= csls_pkg::CH_ZERO && sep <= csls_pkg::CH_NINE))
                sep = "x";
        end
        buffer_bytes.push_back(sep);
        repeat (n) buffer_bytes.push_back(random_byte());
    endfunction

    function automatic void append_list(input int depth);
        int n;
        buffer_bytes.push_back(csls_pkg::CH_OPEN);
        n = $urandom_range(0, 4);
        repeat (n) begin
            if (depth < 3 && $urandom_range(0, 3) == 0)
                append_list(depth + 1);
            else
                append_atom();
        end
        buffer_bytes.push_back(csls_pkg::CH_CLOSE);
    endfunction

    function automatic void build_random_buffer();
        int cut;
        case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6)) buffer_bytes.push_back(random_byte());
            1: begin
                append_list(0);
                cut = $urandom_range(1, buffer_bytes.size());
                while (buffer_bytes.size() > cut)
                    void'(buffer_bytes.pop_back());
            end
            2: begin
                append_list(0);
                buffer_bytes[$urandom_range(0, buffer_bytes.size() - 1)] = random_byte();
            end
            3: begin
                append_list(0);
                repeat ($urandom_range(1, 4)) buffer_bytes.push_back(random_byte());
            end
            default: append_list(0);
        endcase
    endfunction

    initial begin : stimulus
        int random_end;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("()");
        buffer_bytes.push_back(8'hFF);
        send_buffer();
        send_text("(3:abc)");
        append_text("(2:");
        buffer_bytes.push_back(8'h00);
        buffer_bytes.push_back(8'hFF);
        append_text(")");
        send_buffer();
        send_text("( x");
        send_text("(+1:a)");
        send_text("(-1:a)");
        send_text("(\t");
        send_text("(a");
        send_text("(0:)");
        send_text("(00x");
        send_text("(2xab)");
        send_text("(5x");
        send_text("(12");
        send_text("(1:a");
        send_text("((1:a)");
        send_text("(");
        send_text("(99999999:ab");
        send_text("x(((");
        send_text("(2:()(1:z))");

        // deepest legal nesting, then one level too deep
        buffer_bytes.push_back(csls_pkg::CH_OPEN);
        repeat (255) buffer_bytes.push_back(csls_pkg::CH_OPEN);
        repeat (256) buffer_bytes.push_back(csls_pkg::CH_CLOSE);
        send_buffer();
        buffer_bytes.push_back(csls_pkg::CH_OPEN);
        repeat (256) buffer_bytes.push_back(csls_pkg::CH_OPEN);
        buffer_bytes.push_back(csls_pkg::CH_CLOSE);
        send_buffer();

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end) begin
            build_random_buffer();
            send_buffer();
        end
        push <= 1'b0;

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : drain
        int gap;
        bit took;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                took = !empty;
                @(posedge i_clk);
            end while (!took);
        end
    end

endmodule
